/* rtl/gqm_pkg.sv */
// greedy quad mesher package: opcodes, grid geometry and field widths
`default_nettype none
package gqm_pkg;
	localparam int GRID_BITS = 5;
	localparam int ADDR_W = 2 * GRID_BITS;
	localparam int TYPE_W = 6;
	localparam int IDX_W = 12;
	localparam int X_W = 12;
	localparam int Y_W = 17;
	localparam int ROW_ORG_W = 16;
	localparam int SIZE_W = 6;
	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_LOAD  = 2'd1,
		OP_FETCH = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;
endpackage
`default_nettype wire

/* rtl/greedy_quad_mesher.sv */
// greedy quad mesher top level: cell and mark memories with the meshing sequencer
//
// in channel: tuser is the opcode (start, load, fetch); tdata carries chunk
// index, cell column, cell row and cell type. start and load give no item;
// every fetch gives one item on the out channel.
// out channel: tuser is found; tdata carries type, world x, world y, width
// and height of the next rectangle, or all zero once the chunk is exhausted.
// cfg channel: row origin, always ready, to be written while the block is idle.
// items are handled one at a time. a load writes the cell memory while idle; a
// start sets the chunk origin and then runs a sweep that clears the consumed
// marks. a fetch walks cells through the single read port of the memories:
// a read and a check step per visited cell while scanning and growing the
// column, the same per cell checked while widening and a mark step per cell
// marked, plus column and type steps.
// after reset the same sweep runs and s_axis_tready stays low.
// a finished result waits in the output register; a new item is accepted
// meanwhile, and a further result waits until the receiver takes the first.
`default_nettype none
module greedy_quad_mesher #(
	parameter int CHUNK_SIDE = 20,
	parameter int CHUNKS_PER_ROW = 54,
	parameter int TYPE_COUNT = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// chunk_index, cell_col, cell_row, cell_type, zero fill
	input  wire logic [gqm_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// opcode
	input  wire logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	// rect_type, rect_x, rect_y, rect_width, rect_height, zero fill
	output logic [gqm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// found
	output logic m_axis_tuser,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [gqm_pkg::ROW_ORG_W-1:0] cfg_data
);
	localparam logic [6:0] SIDE = 7'(CHUNK_SIDE);
	localparam logic [5:0] LAST_TYPE = 6'(TYPE_COUNT - 2);
	localparam logic [5:0] END_TYPE = 6'(TYPE_COUNT - 1);
	localparam int DEPTH = 1 << gqm_pkg::ADDR_W;
	// reciprocal of the chunks per row, exact for every 12 bit index
	localparam int DIV_SHIFT = 24;
	localparam logic [24:0] DIV_MUL =
		25'(((1 << DIV_SHIFT) + CHUNKS_PER_ROW - 1) / CHUNKS_PER_ROW);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_ORG, ST_SCAN_RD, ST_SCAN_CK, ST_RUN_RD, ST_RUN_CK,
		ST_WID_ST, ST_WID_RD, ST_WID_CK, ST_MARK, ST_FIN
	} state_t;

	state_t state_q;
	logic [gqm_pkg::TYPE_W-1:0] cell_mem [DEPTH];
	logic mark_mem [DEPTH];
	logic [gqm_pkg::TYPE_W-1:0] cell_rd_q;
	logic mark_rd_q;
	logic [gqm_pkg::ADDR_W-1:0] clr_q;
	logic [gqm_pkg::ROW_ORG_W-1:0] row_org_q;
	logic [gqm_pkg::X_W-1:0] org_x_q;
	logic [gqm_pkg::Y_W-1:0] org_y_q;
	logic [gqm_pkg::IDX_W-1:0] idx_q, quo_q;
	logic [5:0] t_q, c_q, r_q, h_q, w_q, p_q;
	logic fnd_q;
	logic out_v_q, out_user_q;
	logic [gqm_pkg::OUT_DATA_W-1:0] out_data_q;

	logic in_acc;
	gqm_pkg::opcode_t op;
	logic [gqm_pkg::IDX_W-1:0] in_idx;
	logic [4:0] in_col, in_row;
	logic [gqm_pkg::TYPE_W-1:0] in_type;
	logic load_we;
	logic [6:0] cw_sum, rh_sum, rp_sum;
	logic [gqm_pkg::ADDR_W-1:0] rd_addr, mark_wa;
	logic mark_we, mark_wd, match;
	logic [35:0] quo_prod;
	logic [gqm_pkg::IDX_W-1:0] chunk_col, chunk_row;
	logic [gqm_pkg::Y_W-1:0] start_y;
	logic [gqm_pkg::X_W-1:0] res_x;
	logic [gqm_pkg::Y_W-1:0] res_y;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign op = gqm_pkg::opcode_t'(s_axis_tuser);
	assign in_idx = s_axis_tdata[11:0];
	assign in_col = s_axis_tdata[16:12];
	assign in_row = s_axis_tdata[21:17];
	assign in_type = s_axis_tdata[27:22];
	assign load_we = in_acc && (op == gqm_pkg::OP_LOAD)
		&& ({2'b0, in_col} < SIDE) && ({2'b0, in_row} < SIDE);

	assign cw_sum = {1'b0, c_q} + {1'b0, w_q};
	assign rh_sum = {1'b0, r_q} + {1'b0, h_q};
	assign rp_sum = {1'b0, r_q} + {1'b0, p_q};
	assign match = (cell_rd_q == t_q) && !mark_rd_q;

	always_comb begin
		case (state_q)
			ST_RUN_RD: rd_addr = {c_q[4:0], rh_sum[4:0]};
			ST_WID_RD: rd_addr = {cw_sum[4:0], rp_sum[4:0]};
			default:   rd_addr = {c_q[4:0], r_q[4:0]};
		endcase
	end

	assign mark_we = (state_q == ST_CLEAR) || (state_q == ST_MARK);
	assign mark_wd = (state_q == ST_MARK);
	assign mark_wa = (state_q == ST_CLEAR) ? clr_q : {cw_sum[4:0], rp_sum[4:0]};

	assign quo_prod = 36'(in_idx) * 36'(DIV_MUL);
	assign chunk_row = quo_q;
	assign chunk_col = idx_q - 12'(quo_q * CHUNKS_PER_ROW);
	assign start_y = 17'(chunk_row * CHUNK_SIDE)
		+ {row_org_q[gqm_pkg::ROW_ORG_W-1], row_org_q};
	assign res_x = org_x_q + {6'b0, c_q};
	assign res_y = org_y_q + {11'b0, r_q};

	always_ff @(posedge clk) begin
		if (load_we) begin
			cell_mem[{in_col, in_row}] <= in_type;
		end
		cell_rd_q <= cell_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_wa] <= mark_wd;
		end
		mark_rd_q <= mark_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_org_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			row_org_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			org_x_q <= '0;
			org_y_q <= '0;
			idx_q <= '0;
			quo_q <= '0;
			t_q <= '0;
			c_q <= '0;
			r_q <= '0;
			h_q <= '0;
			w_q <= '0;
			p_q <= '0;
			fnd_q <= 1'b0;
			out_v_q <= 1'b0;
			out_user_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			if (out_v_q && m_axis_tready && (state_q != ST_FIN)) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						case (op)
							gqm_pkg::OP_START: begin
								idx_q <= in_idx;
								quo_q <= quo_prod[35:24];
								t_q <= '0;
								c_q <= '0;
								r_q <= '0;
								state_q <= ST_ORG;
							end
							gqm_pkg::OP_FETCH: state_q <= ST_SCAN_RD;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ORG: begin
					org_x_q <= 12'(chunk_col * CHUNK_SIDE);
					org_y_q <= start_y;
					clr_q <= '0;
					state_q <= ST_CLEAR;
				end
				ST_SCAN_RD: begin
					if (t_q > LAST_TYPE) begin
						t_q <= END_TYPE;
						c_q <= '0;
						r_q <= '0;
						fnd_q <= 1'b0;
						state_q <= ST_FIN;
					end else if (t_q == '0) begin
						t_q <= 6'd1;
						c_q <= '0;
						r_q <= '0;
					end else if ({1'b0, c_q} >= SIDE) begin
						t_q <= t_q + 1'b1;
						c_q <= '0;
						r_q <= '0;
					end else if ({1'b0, r_q} >= SIDE) begin
						r_q <= '0;
						c_q <= c_q + 1'b1;
					end else begin
						state_q <= ST_SCAN_CK;
					end
				end
				ST_SCAN_CK: begin
					if (match) begin
						h_q <= 6'd1;
						state_q <= ST_RUN_RD;
					end else begin
						r_q <= r_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_RUN_RD: begin
					if (rh_sum < SIDE) begin
						state_q <= ST_RUN_CK;
					end else begin
						w_q <= 6'd1;
						state_q <= ST_WID_ST;
					end
				end
				ST_RUN_CK: begin
					if (match) begin
						h_q <= h_q + 1'b1;
						state_q <= ST_RUN_RD;
					end else begin
						w_q <= 6'd1;
						state_q <= ST_WID_ST;
					end
				end
				ST_WID_ST: begin
					p_q <= '0;
					if (cw_sum < SIDE) begin
						state_q <= ST_WID_RD;
					end else begin
						fnd_q <= 1'b1;
						state_q <= ST_FIN;
					end
				end
				ST_WID_RD: begin
					if (p_q == h_q) begin
						p_q <= '0;
						state_q <= ST_MARK;
					end else begin
						state_q <= ST_WID_CK;
					end
				end
				ST_WID_CK: begin
					if (match) begin
						p_q <= p_q + 1'b1;
						state_q <= ST_WID_RD;
					end else begin
						fnd_q <= 1'b1;
						state_q <= ST_FIN;
					end
				end
				ST_MARK: begin
					p_q <= p_q + 1'b1;
					if (p_q + 6'd1 == h_q) begin
						w_q <= w_q + 1'b1;
						state_q <= ST_WID_ST;
					end
				end
				ST_FIN: begin
					if (!out_v_q || m_axis_tready) begin
						out_v_q <= 1'b1;
						out_user_q <= fnd_q;
						if (fnd_q) begin
							out_data_q <= {1'b0, h_q, w_q, res_y, res_x, t_q};
							r_q <= rh_sum[5:0];
						end else begin
							out_data_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser = out_user_q;
	assign m_axis_tdata = out_data_q;
endmodule
`default_nettype wire

/* rtl/gqm_checker.sv */
// greedy quad mesher port checker and its bind to the top level
`default_nettype none
module gqm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [gqm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic m_axis_tuser
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("exhausted item carries data");

	a_rect_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
		m_axis_tdata[40:35] != 6'd0 && m_axis_tdata[46:41] != 6'd0)
		else $error("rectangle of zero size");

	a_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !s_axis_tready)
		else $error("item accepted before mark sweep");
endmodule

bind greedy_quad_mesher gqm_checker u_gqm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);
`default_nettype wire
